// ----- src/pap_pkg.sv -----
// Shared types and constants for the polygon area block.
// Used by every module under src; depends on nothing.
`default_nettype none

package pap_pkg;

    localparam int COORD_W = 24;                 // vertex coordinate width
    localparam int DIFF_W  = COORD_W + 1;        // coordinate difference width
    localparam int PROD_W  = 2 * DIFF_W;         // one shoelace term
    localparam int SUM_W   = 63;                 // saturated sums and result
    localparam int MAX_RING_POINTS_DEF = 4096;
    localparam int QUEUE_DEPTH = 4;              // front-to-back queue words

    localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W - 1){1'b0}}};

    typedef struct packed {
        logic end_ring;     // word closes a ring
        logic ring_long;    // closing ring kept 3 or more points
        logic hole;         // closing ring is a hole
        logic end_poly;     // word closes the polygon
    } pap_flags_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     term;   // dx * dy joins the ring sum
        pap_flags_t               flags;
    } pap_item_t;

endpackage

`default_nettype wire

// ----- src/polygon_area_with_holes.sv -----
// Top level of the streaming polygon area block (doubled area, holes subtracted).
// Depends on pap_pkg, pap_front, pap_queue and pap_back.
//
//   port group   dir   words                          flow control
//   s_*          in    one vertex per word            s_valid / s_ready
//   m_*          out   one result per polygon         m_valid / m_ready
//
// One vertex word per cycle sustained while no result stalls; the multiply-accumulate
// in pap_back takes one word each cycle that it advances.
// After its closing vertex word, a result passes the queue, multiply stage, ring stage and result register.
// Reset (aresetn low, synchronous) clears ring, polygon and queue state at once.
// A stalled result holds the back end; the 4-word queue keeps s_ready high
// until it fills.
`default_nettype none

module polygon_area_with_holes import pap_pkg::*; #(
    parameter int MAX_RING_POINTS = MAX_RING_POINTS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [COORD_W-1:0] s_x,
    input  wire logic signed [COORD_W-1:0] s_y,
    input  wire logic                      s_is_hole,
    input  wire logic                      s_last_in_ring,
    input  wire logic                      s_last_in_polygon,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [SUM_W-1:0]        m_area_times_two,
    output logic                           m_overflow
);

    pap_item_t front_item;
    pap_item_t head_item;
    logic      accept;
    logic      head_valid;
    logic      pop;

    assign accept = s_valid && s_ready;

    pap_front #(
        .MAX_RING_POINTS (MAX_RING_POINTS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .x               (s_x),
        .y               (s_y),
        .is_hole         (s_is_hole),
        .last_in_ring    (s_last_in_ring),
        .last_in_polygon (s_last_in_polygon),
        .item            (front_item)
    );

    pap_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (front_item),
        .not_full  (s_ready),
        .pop       (pop),
        .not_empty (head_valid),
        .head_item (head_item)
    );

    pap_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (head_valid),
        .in_item          (head_item),
        .in_pop           (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_area_times_two (m_area_times_two),
        .m_overflow       (m_overflow)
    );

endmodule

`default_nettype wire

// ----- src/pap_front.sv -----
// Front end: tracks ring position and classifies each vertex word.
// Depends on pap_pkg.
`default_nettype none

module pap_front import pap_pkg::*; #(
    parameter int MAX_RING_POINTS = MAX_RING_POINTS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      accept,
    input  wire logic signed [COORD_W-1:0] x,
    input  wire logic signed [COORD_W-1:0] y,
    input  wire logic                      is_hole,
    input  wire logic                      last_in_ring,
    input  wire logic                      last_in_polygon,
    output pap_item_t                      item
);

    localparam int CNT_W = $clog2(MAX_RING_POINTS + 1);

    logic signed [COORD_W-1:0] first_x_reg, first_x_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_W-1:0] prev_y_reg, prev_y_next;
    logic signed [COORD_W-1:0] prev_prev_y_reg, prev_prev_y_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          count_inc;
    logic                      keep;
    logic                      end_ring;

    assign keep      = count_reg < CNT_W'(MAX_RING_POINTS);
    assign count_inc = keep ? count_reg + CNT_W'(1) : count_reg;
    assign end_ring  = last_in_ring | last_in_polygon;

    always_comb begin
        item.dx             = DIFF_W'(prev_x_reg) - DIFF_W'(first_x_reg);
        item.dy             = DIFF_W'(prev_prev_y_reg) - DIFF_W'(y);
        item.term           = keep && (count_reg >= CNT_W'(2));
        item.flags.end_ring  = end_ring;
        item.flags.ring_long = count_inc >= CNT_W'(3);
        item.flags.hole      = is_hole;
        item.flags.end_poly  = last_in_polygon;
    end

    always_comb begin
        first_x_next     = first_x_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        prev_prev_y_next = prev_prev_y_reg;
        count_next       = count_reg;
        if (accept) begin
            if (end_ring) begin
                // ring closes: start the next one from scratch
                first_x_next     = '0;
                prev_x_next      = '0;
                prev_y_next      = '0;
                prev_prev_y_next = '0;
                count_next       = '0;
            end else if (keep) begin
                if (count_reg == '0) begin
                    first_x_next = x;
                end
                prev_prev_y_next = prev_y_reg;
                prev_y_next      = y;
                prev_x_next      = x;
                count_next       = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_x_reg     <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_prev_y_reg <= '0;
            count_reg       <= '0;
        end else begin
            first_x_reg     <= first_x_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            prev_prev_y_reg <= prev_prev_y_next;
            count_reg       <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pap_queue.sv -----
// Short queue of classified words between front and back end.
// Depends on pap_pkg.
`default_nettype none

module pap_queue import pap_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  pap_item_t       push_item,
    output logic            not_full,
    input  wire logic       pop,
    output logic            not_empty,
    output pap_item_t       head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    pap_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     fill_reg, fill_next;
    logic               do_push;
    logic               do_pop;

    assign not_full  = fill_reg != (PTR_W + 1)'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (PTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pap_back.sv -----
// Back end: multiply, ring accumulate, polygon accumulate into the result register.
// Depends on pap_pkg.
`default_nettype none

module pap_back import pap_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    input  pap_item_t                    in_item,
    output logic                         in_pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [SUM_W-1:0]      m_area_times_two,
    output logic                         m_overflow
);

    // multiply stage
    logic                      a_valid_reg;
    logic signed [PROD_W-1:0]  a_prod_reg;
    pap_flags_t                a_flags_reg;
    // ring stage
    logic                      b_valid_reg;
    logic signed [SUM_W-1:0]   b_ring_reg;
    logic                      b_sat_reg;
    pap_flags_t                b_flags_reg;
    // running sums
    logic signed [SUM_W-1:0]   ring_sum_reg, ring_sum_next;
    logic signed [SUM_W-1:0]   poly_sum_reg, poly_sum_next;
    logic                      sat_reg, sat_next;
    // result register
    logic                      out_valid_reg;
    logic signed [SUM_W-1:0]   out_area_reg;
    logic                      out_ovf_reg;

    logic                      advance;
    logic signed [DIFF_W-1:0]  dx_s;
    logic signed [DIFF_W-1:0]  dy_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W:0]     ring_wide;
    logic signed [SUM_W-1:0]   ring_clamped;
    logic                      ring_sat;
    logic signed [SUM_W+1:0]   ring_ext;
    logic signed [SUM_W+1:0]   poly_wide;
    logic signed [SUM_W-1:0]   poly_clamped;
    logic                      poly_sat;
    logic                      use_ring;
    logic                      overflow_now;

    // hold everything while a result waits
    assign advance = !out_valid_reg || m_ready;
    assign in_pop  = advance;

    assign dx_s = in_item.dx;
    assign dy_s = in_item.dy;
    assign prod = PROD_W'(dx_s) * PROD_W'(dy_s);

    always_comb begin
        ring_wide = (SUM_W + 1)'(ring_sum_reg) + (SUM_W + 1)'(a_prod_reg);
        ring_sat  = 1'b0;
        if (ring_wide > SUM_MAX) begin
            ring_clamped = SUM_MAX[SUM_W-1:0];
            ring_sat     = 1'b1;
        end else if (ring_wide < SUM_MIN) begin
            ring_clamped = SUM_MIN[SUM_W-1:0];
            ring_sat     = 1'b1;
        end else begin
            ring_clamped = ring_wide[SUM_W-1:0];
        end
        ring_sum_next = ring_sum_reg;
        if (advance && a_valid_reg) begin
            ring_sum_next = a_flags_reg.end_ring ? '0 : ring_clamped;
        end
    end

    always_comb begin
        use_ring = b_flags_reg.end_ring && b_flags_reg.ring_long;
        ring_ext = (SUM_W + 2)'(b_ring_reg);
        // add the magnitude for an exterior ring, subtract it for a hole
        if (!use_ring) begin
            poly_wide = (SUM_W + 2)'(poly_sum_reg);
        end else if (b_flags_reg.hole ^ b_ring_reg[SUM_W-1]) begin
            poly_wide = (SUM_W + 2)'(poly_sum_reg) - ring_ext;
        end else begin
            poly_wide = (SUM_W + 2)'(poly_sum_reg) + ring_ext;
        end
        poly_sat = 1'b0;
        if (poly_wide > (SUM_W + 2)'(SUM_MAX)) begin
            poly_clamped = SUM_MAX[SUM_W-1:0];
            poly_sat     = 1'b1;
        end else if (poly_wide < (SUM_W + 2)'(SUM_MIN)) begin
            poly_clamped = SUM_MIN[SUM_W-1:0];
            poly_sat     = 1'b1;
        end else begin
            poly_clamped = poly_wide[SUM_W-1:0];
        end
        overflow_now  = sat_reg | b_sat_reg | poly_sat;
        poly_sum_next = poly_sum_reg;
        sat_next      = sat_reg;
        if (advance && b_valid_reg) begin
            poly_sum_next = b_flags_reg.end_poly ? '0 : poly_clamped;
            sat_next      = b_flags_reg.end_poly ? 1'b0 : overflow_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_prod_reg   <= in_item.term ? prod : '0;
            a_flags_reg  <= in_item.flags;
            b_ring_reg   <= ring_clamped;
            b_sat_reg    <= ring_sat;
            b_flags_reg  <= a_flags_reg;
            out_area_reg <= poly_clamped;
            out_ovf_reg  <= overflow_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ring_sum_reg  <= '0;
            poly_sum_reg  <= '0;
            sat_reg       <= 1'b0;
        end else begin
            if (advance) begin
                a_valid_reg   <= in_valid;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg && b_flags_reg.end_poly;
            end
            ring_sum_reg <= ring_sum_next;
            poly_sum_reg <= poly_sum_next;
            sat_reg      <= sat_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_area_times_two = out_area_reg;
    assign m_overflow       = out_ovf_reg;

endmodule

`default_nettype wire

// ----- src/pap_checker.sv -----
// Port-level checks for polygon_area_with_holes, bound to the top level.
// Depends on pap_pkg.
`default_nettype none

module pap_checker import pap_pkg::*; (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic signed [SUM_W-1:0]   m_area_times_two,
    input wire logic                      m_overflow
);

    // no result can reach the output while the pipeline refills after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid ##1 !m_valid ##1 !m_valid)
        else $error("result word too soon after reset");

    // queue is empty after reset, so input is open
    assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_area_times_two) && $stable(m_overflow))
        else $error("stalled result word changed");

endmodule

bind polygon_area_with_holes pap_checker u_pap_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_area_times_two (m_area_times_two),
    .m_overflow       (m_overflow)
);

`default_nettype wire
